### sv/tcw_pkg.sv
// shared codes, constants and types of the text console writer
package tcw_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam int         TAB_CELLS  = 4;

  typedef struct packed {
    logic write_cell;
    logic blank_cell;
    logic scroll;
  } step_flags_t;

endpackage

### sv/tcw_cursor_step.sv
// next cursor position and cell action for one written character code
module tcw_cursor_step #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic [$clog2(ROWS)-1:0]    row,
  input  logic [$clog2(COLUMNS)-1:0] col,
  input  logic [7:0]                 char_code,
  output logic [$clog2(ROWS)-1:0]    row_next,
  output logic [$clog2(COLUMNS)-1:0] col_next,
  output tcw_pkg::step_flags_t       flags
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW:0]   COLS_W   = (CW + 1)'(COLUMNS);

  logic [CW:0] col_sum;
  logic        adv_row;

  always_comb begin
    adv_row  = 1'b0;
    row_next = row;
    col_next = col;
    flags    = '0;
    col_sum  = '0;
    unique case (char_code)
      tcw_pkg::CH_NEWLINE: begin
        adv_row  = 1'b1;
        col_next = '0;
      end
      tcw_pkg::CH_RETURN: begin
        col_next = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_sum = {1'b0, col} + (CW + 1)'(tcw_pkg::TAB_CELLS);
        if (col_sum >= COLS_W) begin
          adv_row  = 1'b1;
          col_next = CW'(col_sum - COLS_W);
        end else begin
          col_next = CW'(col_sum);
        end
      end
      tcw_pkg::CH_BACKSPACE: begin
        flags.blank_cell = 1'b1;
        // stops at the first cell of the screen
        if (col != '0) begin
          col_next = col - CW'(1);
        end else if (row != '0) begin
          row_next = row - RW'(1);
          col_next = LAST_COL;
        end
      end
      default: begin
        flags.write_cell = 1'b1;
        if (col == LAST_COL) begin
          adv_row  = 1'b1;
          col_next = '0;
        end else begin
          col_next = col + CW'(1);
        end
      end
    endcase
    if (adv_row) begin
      if (row == LAST_ROW) begin
        flags.scroll = 1'b1;
      end else begin
        row_next = row + RW'(1);
      end
    end
  end

endmodule

### sv/text_console_writer_unit.sv
// top level of the text console writer: screen store, cursor and sequencer
// Text console writer. Items arrive on in_valid/in_ready with func, char_code,
// read_row and read_col; each gives exactly one result on out_valid/out_ready
// carrying the cursor after the item, the read cell (zero unless an in-range read) and
// a scroll flag. The attribute byte is written on cfg_valid/cfg_ready/cfg_data
// and is always ready.
// The screen lives in one ROWS*COLUMNS entry memory of 16-bit cells with a
// registered read port, so the sequencer handles one item at a time:
//   character, newline, return, tab: the accept step, then the finish step
//   backspace (read-modify-write) and cell read: the RMW or READ step, then finish
//   scroll or clear: a sweep over every cell, one cell written per cycle
// After reset a clearing pass fills every cell with a space of attribute 7;
// in_ready stays low meanwhile, cfg writes still land.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and runs up to its own result, which then waits for
// the register to empty.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_col,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic       scrolled
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] KEEP_END  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RMW   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state;
  logic          init;
  logic [7:0]    text_attribute;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;

  logic          scroll_mode;
  logic [15:0]   fill_word;
  logic [AW-1:0] ptr;
  logic [AW-1:0] wptr;
  logic          wvalid;
  logic [AW-1:0] bs_addr;
  logic [7:0]    res_char;
  logic [7:0]    res_attr;
  logic          res_scrolled;

  logic [RW-1:0]        step_row;
  logic [CW-1:0]        step_col;
  tcw_pkg::step_flags_t step_flags;
  logic [AW-1:0]        cur_addr;
  logic [AW-1:0]        step_addr;
  logic [AW-1:0]        read_addr;
  logic                 rd_in_range;

  tcw_cursor_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .row       (cur_row),
    .col       (cur_col),
    .char_code (char_code),
    .row_next  (step_row),
    .col_next  (step_col),
    .flags     (step_flags)
  );

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == S_IDLE);
  assign cur_addr    = AW'(cur_row) * COLS_A + AW'(cur_col);
  assign step_addr   = AW'(step_row) * COLS_A + AW'(step_col);
  assign rd_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
  assign read_addr   = AW'(RW'(read_row)) * COLS_A + AW'(CW'(read_col));

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && func == tcw_pkg::FUNC_WRITE) begin
          if (step_flags.write_cell) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {text_attribute, char_code};
          end
          if (step_flags.blank_cell) begin
            raddr = step_addr;
          end
        end else if (in_valid && func == tcw_pkg::FUNC_READ && rd_in_range) begin
          raddr = read_addr;
        end
      end
      S_RMW: begin
        we    = 1'b1;
        waddr = bs_addr;
        wdata = {rdata[15:8], tcw_pkg::BLANK_CHAR};
      end
      S_SWEEP: begin
        // source row lies one row below the cell being written
        if (scroll_mode && ptr < KEEP_END) begin
          raddr = AW'({1'b0, ptr} + {1'b0, COLS_A});
        end
        if (wvalid) begin
          we    = 1'b1;
          waddr = wptr;
          wdata = (scroll_mode && wptr < KEEP_END) ? rdata : fill_word;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_SWEEP;
      init           <= 1'b1;
      scroll_mode    <= 1'b0;
      fill_word      <= {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      ptr            <= '0;
      wptr           <= '0;
      wvalid         <= 1'b0;
      text_attribute <= tcw_pkg::RESET_ATTR;
      cur_row        <= '0;
      cur_col        <= '0;
      out_valid      <= 1'b0;
      bs_addr        <= '0;
      res_char       <= '0;
      res_attr       <= '0;
      res_scrolled   <= 1'b0;
      cursor_row     <= '0;
      cursor_col     <= '0;
      cell_char      <= '0;
      cell_attr      <= '0;
      scrolled       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        text_attribute <= cfg_data;
      end
      // the finish step decides out_valid itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_char     <= '0;
            res_attr     <= '0;
            res_scrolled <= 1'b0;
            fill_word    <= {text_attribute, tcw_pkg::BLANK_CHAR};
            ptr          <= '0;
            wvalid       <= 1'b0;
            unique case (func)
              tcw_pkg::FUNC_WRITE: begin
                cur_row      <= step_row;
                cur_col      <= step_col;
                res_scrolled <= step_flags.scroll;
                bs_addr      <= step_addr;
                scroll_mode  <= 1'b1;
                if (step_flags.blank_cell) begin
                  state <= S_RMW;
                end else if (step_flags.scroll) begin
                  state <= S_SWEEP;
                end else begin
                  state <= S_FIN;
                end
              end
              tcw_pkg::FUNC_READ: begin
                state <= rd_in_range ? S_READ : S_FIN;
              end
              tcw_pkg::FUNC_CLEAR: begin
                cur_row     <= '0;
                cur_col     <= '0;
                scroll_mode <= 1'b0;
                state       <= S_SWEEP;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_RMW: begin
          state <= S_FIN;
        end
        S_READ: begin
          res_char <= rdata[7:0];
          res_attr <= rdata[15:8];
          state    <= S_FIN;
        end
        S_SWEEP: begin
          ptr    <= ptr + AW'(1);
          wptr   <= ptr;
          wvalid <= 1'b1;
          if (wvalid && wptr == LAST_CELL) begin
            init  <= 1'b0;
            state <= init ? S_IDLE : S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            cursor_row <= 5'(cur_row);
            cursor_col <= 7'(cur_col);
            cell_char  <= res_char;
            cell_attr  <= res_attr;
            scrolled   <= res_scrolled;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_item_during_init: assert property (@(posedge clk) disable iff (rst)
    init |-> !in_ready)
    else $error("item taken during the clearing pass");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_row) < ROWS) && (int'(cur_col) < COLUMNS))
    else $error("cursor left the screen");

  a_clear_homes_cursor: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == tcw_pkg::FUNC_CLEAR)
      |=> (cur_row == '0 && cur_col == '0))
    else $error("clear did not home the cursor");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result loaded outside the finish step");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && wvalid) |-> wptr <= LAST_CELL)
    else $error("sweep ran past the last cell");

endmodule

### test/tcw_console_checker.sv
// checker for the text console writer: screen and cursor prediction, result comparison
`timescale 1ns / 100ps

module tcw_console_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] char_code,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [4:0] cursor_row,
  input  logic [6:0] cursor_col,
  input  logic [7:0] cell_char,
  input  logic [7:0] cell_attr,
  input  logic       scrolled,
  output int         mismatches,
  output int         outputs_in_flight
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    logic [7:0] attr;
    logic       scrolled;
  } console_out_t;

  logic [15:0]  screen_model [0:CELLS-1];
  int           cursor_cell;
  logic [7:0]   text_attr;
  console_out_t console_outputs_due [$];

  initial mismatches = 0;
  initial outputs_in_flight = 0;

  // apply one item to the screen copy and work out what the block reports
  task automatic advance_console(input logic [1:0] f, input logic [7:0] ch,
                                 input logic [4:0] r, input logic [6:0] c,
                                 output console_out_t res);
    int cur;
    logic [15:0] cell_word;
    res = '0;
    case (f)
      tcw_pkg::FUNC_WRITE: begin
        cur = cursor_cell;
        if (ch == tcw_pkg::CH_NEWLINE) begin
          cur = (cur / COLUMNS) * COLUMNS + COLUMNS;
        end else if (ch == tcw_pkg::CH_RETURN) begin
          cur = (cur / COLUMNS) * COLUMNS;
        end else if (ch == tcw_pkg::CH_TAB) begin
          cur = cur + tcw_pkg::TAB_CELLS;
        end else if (ch == tcw_pkg::CH_BACKSPACE) begin
          // saturates at the first cell, attribute kept
          if (cur > 0) cur = cur - 1;
          screen_model[cur][7:0] = tcw_pkg::BLANK_CHAR;
        end else begin
          screen_model[cur] = {text_attr, ch};
          cur = cur + 1;
        end
        if (cur >= CELLS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = {text_attr, tcw_pkg::BLANK_CHAR};
          cur = cur - COLUMNS;
          if (cur >= CELLS) cur = CELLS - 1;
          res.scrolled = 1'b1;
        end
        cursor_cell = cur;
      end
      tcw_pkg::FUNC_READ: begin
        if (int'(r) < ROWS && int'(c) < COLUMNS) begin
          cell_word = screen_model[int'(r) * COLUMNS + int'(c)];
          res.ch = cell_word[7:0];
          res.attr = cell_word[15:8];
        end
      end
      tcw_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {text_attr, tcw_pkg::BLANK_CHAR};
        cursor_cell = 0;
      end
      default: begin
      end
    endcase
    res.row = 5'(cursor_cell / COLUMNS);
    res.col = 7'(cursor_cell % COLUMNS);
  endtask

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    console_out_t predicted;
    console_out_t oldest;
    if (rst) begin
      for (int i = 0; i < CELLS; i++)
        screen_model[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      cursor_cell = 0;
      text_attr = tcw_pkg::RESET_ATTR;
      console_outputs_due.delete();
      outputs_in_flight <= 0;
    end else begin
      if (cfg_valid && cfg_ready) text_attr = cfg_data;
      if (in_valid && in_ready) begin
        advance_console(func, char_code, read_row, read_col, predicted);
        console_outputs_due.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (console_outputs_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing outstanding, expected none, got row %0d col %0d",
                   $time, cursor_row, cursor_col);
        end else begin
          oldest = console_outputs_due.pop_front();
          check_field("cursor_row", oldest.row, cursor_row);
          check_field("cursor_col", oldest.col, cursor_col);
          check_field("cell_char", oldest.ch, cell_char);
          check_field("cell_attr", oldest.attr, cell_attr);
          check_field("scrolled", oldest.scrolled, scrolled);
        end
      end
      outputs_in_flight <= console_outputs_due.size();
    end
  end

endmodule

### test/tb.sv
// testbench top for the text console writer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;

  localparam int         COLUMNS       = 80;
  localparam int         ROWS          = 25;
  localparam int         STALL_LIMIT   = 20000;
  localparam int         PHASES        = 10;
  localparam int         PHASE_ITEMS   = 53;
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'h00;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] func      = tcw_pkg::FUNC_WRITE;
  logic [7:0] char_code = 8'h00;
  logic [4:0] read_row  = 5'd0;
  logic [6:0] read_col  = 7'd0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic       scrolled;

  int         check_failures;
  int         outputs_in_flight;
  int         quiet_cycles = 0;
  bit         sender_idle = 1'b0;
  bit         receiver_stall = 1'b0;
  bit         long_hold = 1'b0;
  logic [4:0] recent_row = 5'd0;

  text_console_writer_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .char_code(char_code), .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_row(cursor_row), .cursor_col(cursor_col),
    .cell_char(cell_char), .cell_attr(cell_attr), .scrolled(scrolled)
  );

  tcw_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) console_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .char_code(char_code), .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_row(cursor_row), .cursor_col(cursor_col),
    .cell_char(cell_char), .cell_attr(cell_attr), .scrolled(scrolled),
    .mismatches(check_failures), .outputs_in_flight(outputs_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // row the cursor was last seen on, so reads land near fresh text
  always @(posedge clk) begin
    if (out_valid && out_ready) recent_row <= cursor_row;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: short random stalls, and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ready <= 1'b1;
        long_hold = 1'b0;
      end else if (receiver_stall && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] f, input logic [7:0] ch,
                           input logic [4:0] r, input logic [6:0] c);
    in_valid  <= 1'b1;
    func      <= f;
    char_code <= ch;
    read_row  <= r;
    read_col  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every item has produced its result
  task automatic drain_console;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outputs_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] attr);
    cfg_data  <= attr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // line-heavy items push the cursor down to the bottom and keep scrolling
  task automatic send_random_item(input bit line_heavy);
    int         pick;
    int         newline_pct;
    int         clear_pct;
    logic [1:0] f;
    logic [7:0] ch;
    logic [4:0] r;
    logic [6:0] c;
    newline_pct = line_heavy ? 40 : 3;
    clear_pct   = line_heavy ? 0 : 2;
    ch = 8'($urandom_range(0, 255));
    r  = 5'($urandom_range(0, 31));
    c  = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      f = tcw_pkg::FUNC_WRITE;
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) ch = tcw_pkg::CH_NEWLINE;
      else if (pick < newline_pct + 6) ch = tcw_pkg::CH_TAB;
      else if (pick < newline_pct + 12) ch = tcw_pkg::CH_BACKSPACE;
      else if (pick < newline_pct + 16) ch = tcw_pkg::CH_RETURN;
    end else if (pick < 94) begin
      f = tcw_pkg::FUNC_READ;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        r = recent_row;
        c = 7'($urandom_range(0, COLUMNS - 1));
      end else if (pick < 8) begin
        r = 5'($urandom_range(0, ROWS - 1));
        c = 7'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < 98 - clear_pct) begin
      f = FUNC_RESERVED;
    end else if (pick < 98) begin
      f = tcw_pkg::FUNC_CLEAR;
    end else begin
      f = tcw_pkg::FUNC_READ;
    end
    send_item(f, ch, r, c);
  endtask

  initial begin
    logic [7:0] attr;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, byte extremes, control codes, edge reads
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, 8'hff, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, 8'h00, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, tcw_pkg::CH_TAB, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, 8'h41, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, tcw_pkg::CH_RETURN, 5'd0, 7'd0);
    // backspace at the very first cell saturates
    send_item(tcw_pkg::FUNC_WRITE, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, 8'h55, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, 8'h7f, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_WRITE, tcw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd1, 7'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd1, 7'd1);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd5);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd24, 7'd79);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd25, 7'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd80);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'h1f, 7'h7f);
    send_item(FUNC_RESERVED, 8'hff, 5'h1f, 7'h7f);
    send_item(tcw_pkg::FUNC_CLEAR, 8'h00, 5'd0, 7'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 5'd0, 7'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_console();
      if (phase == 0) attr = 8'h00;
      else if (phase == 1) attr = 8'hff;
      else attr = 8'($urandom_range(0, 255));
      write_attribute(attr);
      // no idling at all in the closing phase
      sender_idle    = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
      receiver_stall = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (phase == 2) long_hold = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 4 && k == PHASE_ITEMS / 2) drain_console();
        send_random_item(phase % 2 == 1);
      end
    end

    drain_console();
    repeat (20) @(posedge clk);
    if (check_failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
